@@ rtl/core/mbps_pkg.sv @@
package mbps_pkg;

  // default window depth and fixed pattern storage
  localparam int PATTERN_MAX_DEF = 32;
  localparam int PAT_BYTES       = 32;
  localparam int PAT_REGS        = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ADDR_W     = 32;
  localparam int LEN_CFG_W  = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION    = 3'd7;

  // scan limits precomputed from configuration
  typedef struct packed {
    logic              settle;    // derived values still updating
    logic [5:0]        span_m1;   // effective length minus one, zero length counts as one
    logic [ADDR_W:0]   limit;     // region_size + span_m1
    logic [ADDR_W-1:0] addr_off;  // base_address - span_m1
  } mbps_scan_cfg_t;

endpackage

@@ rtl/core/mbps_cfg.sv @@
module mbps_cfg #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   wr_en,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]         wr_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]        wr_data,
  output mbps_pkg::mbps_scan_cfg_t               scan_cfg,
  output logic [PATTERN_MAX-1:0][7:0]            apat,
  output logic [PATTERN_MAX-1:0]                 acare
);
  import mbps_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic [PAT_REGS-1:0][CFG_DATA_W-1:0] pat_r;
  logic [31:0]                         care_r;
  logic [LEN_CFG_W-1:0]                len_r;
  logic [ADDR_W-1:0]                   base_r;
  logic [ADDR_W-1:0]                   region_r;
  logic                                settle_r;

  logic [LEN_W-1:0]                    len_sat;
  logic [6:0]                          span7;
  logic [5:0]                          span_m1;
  logic [PAT_BYTES*8-1:0]              pat_flat;

  logic [PATTERN_MAX-1:0][7:0]         apat_r, apat_nxt;
  logic [PATTERN_MAX-1:0]              acare_r, acare_nxt;
  logic [5:0]                          span_m1_r;
  logic [ADDR_W:0]                     limit_r;
  logic [ADDR_W-1:0]                   addr_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r    <= '0;
      care_r   <= '0;
      len_r    <= '0;
      base_r   <= '0;
      region_r <= '0;
      settle_r <= 1'b0;
    end else begin
      settle_r <= wr_en;
      if (wr_en) begin
        unique case (wr_index)
          CFG_PAT_0_7:   pat_r[0] <= wr_data;
          CFG_PAT_8_15:  pat_r[1] <= wr_data;
          CFG_PAT_16_23: pat_r[2] <= wr_data;
          CFG_PAT_24_31: pat_r[3] <= wr_data;
          CFG_CARE_MASK: care_r   <= wr_data[31:0];
          CFG_PAT_LEN:   len_r    <= wr_data[LEN_CFG_W-1:0];
          CFG_BASE_ADDR: base_r   <= wr_data[ADDR_W-1:0];
          CFG_REGION:    region_r <= wr_data[ADDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // length saturates at window depth
  always_comb begin
    if ({1'b0, len_r} > 7'(PATTERN_MAX)) len_sat = LEN_W'(PATTERN_MAX);
    else                                 len_sat = LEN_W'(len_r);
    span7   = (len_sat == '0) ? 7'd1 : 7'(len_sat);
    span_m1 = 6'(span7 - 7'd1);
  end

  assign pat_flat = pat_r;

  // pattern realigned to window order: window slot j pairs with pattern byte len-1-j
  always_comb begin
    logic [7:0] diff;
    apat_nxt  = '0;
    acare_nxt = '0;
    diff      = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      diff = 8'(len_sat) - 8'(j) - 8'd1;
      if (8'(j) < 8'(len_sat) && diff[7:5] == 3'd0) begin
        apat_nxt[j]  = pat_flat[diff[4:0]*8 +: 8];
        acare_nxt[j] = care_r[diff[4:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    apat_r     <= apat_nxt;
    acare_r    <= acare_nxt;
    span_m1_r  <= span_m1;
    limit_r    <= {1'b0, region_r} + (ADDR_W+1)'(span_m1);
    addr_off_r <= base_r - ADDR_W'(span_m1);
  end

  assign apat              = apat_r;
  assign acare             = acare_r;
  assign scan_cfg.settle   = settle_r;
  assign scan_cfg.span_m1  = span_m1_r;
  assign scan_cfg.limit    = limit_r;
  assign scan_cfg.addr_off = addr_off_r;

endmodule

@@ rtl/core/mbps_scan.sv @@
module mbps_scan #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              proc,
  input  logic [7:0]                        data_byte,
  input  logic                              last,
  input  mbps_pkg::mbps_scan_cfg_t          scan_cfg,
  input  logic [PATTERN_MAX-1:0][7:0]       apat,
  input  logic [PATTERN_MAX-1:0]            acare,
  output logic                              res_valid,
  output logic                              res_found,
  output logic [mbps_pkg::ADDR_W-1:0]       res_addr
);
  import mbps_pkg::*;

  logic [PATTERN_MAX-1:0][7:0] window_r, window_nxt;
  logic [ADDR_W-1:0]           seen_r, seen_nxt;
  logic                        done_r, done_nxt;

  logic [PATTERN_MAX-1:0][7:0] win_new;
  logic [PATTERN_MAX-1:0]      slot_ok;
  logic                        sat, in_range, hit;

  // newest byte in slot 0
  always_comb begin
    win_new[0] = data_byte;
    for (int j = 1; j < PATTERN_MAX; j++) win_new[j] = window_r[j-1];
    for (int j = 0; j < PATTERN_MAX; j++) slot_ok[j] = !acare[j] || (win_new[j] == apat[j]);
  end

  assign sat      = &seen_r;
  // position seen_r+1-span must satisfy 0 <= pos < region_size
  assign in_range = (seen_r >= ADDR_W'(scan_cfg.span_m1)) &&
                    ({1'b0, seen_r} < scan_cfg.limit);
  assign hit      = !done_r && !sat && in_range && (&slot_ok);

  assign res_valid = hit || (last && !done_r);
  assign res_found = hit;
  assign res_addr  = hit ? (scan_cfg.addr_off + seen_r) : '1;

  always_comb begin
    window_nxt = window_r;
    seen_nxt   = seen_r;
    done_nxt   = done_r;
    if (proc) begin
      if (last) begin
        window_nxt = '0;
        seen_nxt   = '0;
        done_nxt   = 1'b0;
      end else begin
        window_nxt = win_new;
        seen_nxt   = sat ? seen_r : seen_r + 1'b1;
        done_nxt   = done_r || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      seen_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      window_r <= window_nxt;
      seen_r   <= seen_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

@@ rtl/core/masked_byte_pattern_scan.sv @@
// an accepted byte passes the input register and is scanned into the result register
// throughput: one byte per cycle when not stalled; the window compare is one parallel stage
// a configuration write holds off input while derived limits update
// reset (rst_n low, synchronous) clears configuration registers, window, byte count and done flag
module masked_byte_pattern_scan #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,   // last byte of the scan
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mbps_pkg::ADDR_W-1:0]         out_tdata,  // [31:0] match_address
  output logic                                out_tuser,  // [0] found
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mbps_pkg::*;

  mbps_scan_cfg_t              scan_cfg;
  logic [PATTERN_MAX-1:0][7:0] apat;
  logic [PATTERN_MAX-1:0]      acare;

  // input register
  logic       a_valid_r;
  logic [7:0] a_byte_r;
  logic       a_last_r;

  // result register
  logic              out_valid_r;
  logic              out_found_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic              b_can, proc, in_acc;
  logic              res_valid, res_found;
  logic [ADDR_W-1:0] res_addr;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  mbps_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .scan_cfg (scan_cfg),
    .apat     (apat),
    .acare    (acare)
  );

  // the result slot frees up when empty or drained this cycle
  assign b_can     = !out_valid_r || out_tready;
  // a word leaves the input register for the scan when the slot is free and settle is low
  assign proc      = a_valid_r && b_can && !scan_cfg.settle;
  assign in_tready = (!a_valid_r || b_can) && !scan_cfg.settle;
  assign in_acc    = in_tvalid && in_tready;

  mbps_scan #(.PATTERN_MAX(PATTERN_MAX)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (proc),
    .data_byte (a_byte_r),
    .last      (a_last_r),
    .scan_cfg  (scan_cfg),
    .apat      (apat),
    .acare     (acare),
    .res_valid (res_valid),
    .res_found (res_found),
    .res_addr  (res_addr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (proc) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_byte_r <= in_tdata;
      a_last_r <= in_tlast;
    end
  end

  // result word loads on a hit or on an end of scan with no earlier hit, otherwise drains when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_found_r <= res_found;
      out_addr_r  <= res_addr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_found_r;

endmodule
